// ===== hdl/rbf_kernel_stream_macros.svh =====
// Assertion macros for the rbf kernel blocks; only the queue uses them.
`ifndef RBF_KERNEL_STREAM_MACROS_SVH
`define RBF_KERNEL_STREAM_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet in reset.
`define RBF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, quiet in reset.
`define RBF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rbf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rbf_pkg;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] feature;
	} item_t;

	typedef struct packed {
		logic [15:0] kernel_value;
		logic        last;
	} result_t;

	localparam int DIST_W = 42;
	localparam int X_W    = 58;
	localparam int XQ_W   = 21;
	localparam int ACC_W  = 31;
	localparam int TBL_N  = 10;

	localparam logic KIND_REF    = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic [7:0] REG_GAMMA        = 8'd0;
	localparam logic [7:0] REG_SAMPLE_COUNT = 8'd1;

	localparam logic [15:0] GAMMA_RST        = 16'd3277;
	localparam logic [15:0] SAMPLE_COUNT_RST = 16'd1;

	// squared distance plus its run flag, queued from front to back
	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              last;
	} dist_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL_LO,
		B_MUL_HI,
		B_SUM,
		B_ROUND,
		B_POLY,
		B_EXP,
		B_OUT
	} back_state_t;

	// exp(-2^(k-6)) in Q0.30
	function automatic logic [29:0] exp_const(input logic [3:0] k);
		logic [29:0] v;
		case (k)
			4'd0: v = 30'd1057095000;
			4'd1: v = 30'd1040706261;
			4'd2: v = 30'd1008687096;
			4'd3: v = 30'd947573834;
			4'd4: v = 30'd836230973;
			4'd5: v = 30'd651257337;
			4'd6: v = 30'd395007542;
			4'd7: v = 30'd145315154;
			4'd8: v = 30'd19666268;
			4'd9: v = 30'd360200;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/rbf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rbf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/rbf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rbf_front
	import rbf_pkg::*;
#(
	parameter int FEATURES = 16,
	parameter int QDEPTH   = 4,
	localparam int PW = (FEATURES > 1) ? $clog2(FEATURES) : 1,
	localparam int QW = $clog2(QDEPTH)
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire item_t       item,
	input  wire logic [15:0] sample_count,
	input  wire logic [QW:0] q_count,
	output logic             push,
	output dist_t            push_data
);
	logic          acc;
	logic [PW-1:0] ref_pos_q;
	logic [PW-1:0] smp_pos_q;
	logic [15:0]   ref_rd;
	logic          v_s1, end_s1;
	logic signed [15:0] feat_s1;
	logic          v_s2, end_s2;
	logic [31:0]   sq_s2;
	logic [DIST_W-1:0] sum_q;
	logic [15:0]   done_q;
	logic [QW+1:0] need;
	logic signed [16:0] diff;
	logic [33:0]   sq_full;
	logic [DIST_W-1:0] sum_next;
	logic          last_now;

	// an item may only enter if every sample end in flight has a queue slot
	assign need = {1'b0, q_count} + (QW+2)'(v_s1 & end_s1) + (QW+2)'(v_s2 & end_s2);
	assign item_ready = need < (QW+2)'(QDEPTH);
	assign acc = item_valid & item_ready;

	rbf_ram #(.WIDTH(16), .DEPTH(FEATURES)) u_ref (
		.clk  (clk),
		.we   (acc & (item.kind == KIND_REF)),
		.waddr(ref_pos_q),
		.wdata(item.feature),
		.raddr(smp_pos_q),
		.rdata(ref_rd)
	);

	assign diff     = 17'(feat_s1) - 17'(signed'(ref_rd));
	assign sq_full  = 34'(diff * diff);
	assign sum_next = sum_q + DIST_W'(sq_s2);
	assign last_now = (17'(done_q) + 17'd1) >= 17'(sample_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_pos_q <= '0;
			smp_pos_q <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			sum_q     <= '0;
			done_q    <= '0;
		end else begin
			v_s1 <= acc & (item.kind == KIND_SAMPLE);
			v_s2 <= v_s1;
			if (acc && item.kind == KIND_REF) begin
				ref_pos_q <= (ref_pos_q == PW'(FEATURES-1)) ? '0 : ref_pos_q + 1'b1;
			end
			if (acc && item.kind == KIND_SAMPLE) begin
				smp_pos_q <= (smp_pos_q == PW'(FEATURES-1)) ? '0 : smp_pos_q + 1'b1;
			end
			if (v_s2) begin
				if (end_s2) begin
					sum_q  <= '0;
					done_q <= last_now ? '0 : done_q + 16'd1;
				end else begin
					sum_q <= sum_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		feat_s1 <= item.feature;
		end_s1  <= smp_pos_q == PW'(FEATURES-1);
		sq_s2   <= sq_full[31:0];
		end_s2  <= end_s1;
	end

	assign push               = v_s2 & end_s2;
	assign push_data.distance = sum_next;
	assign push_data.last     = last_now;
endmodule
`default_nettype wire

// ===== hdl/rbf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "rbf_kernel_stream_macros.svh"
module rbf_queue
	import rbf_pkg::*;
#(
	parameter int QDEPTH = 4,
	localparam int QW = $clog2(QDEPTH)
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire dist_t       push_data,
	input  wire logic        pop,
	output logic             q_valid,
	output dist_t            q_data,
	output logic [QW:0]      q_count
);
	dist_t           slot_q [QDEPTH];
	logic [QW-1:0]   wr_q, rd_q;
	logic [QW:0]     cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QW'(QDEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QW'(QDEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (QW+1)'(push) - (QW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	assign q_valid = cnt_q != '0;
	assign q_data  = slot_q[rd_q];
	assign q_count = cnt_q;

	`RBF_ASSERT_NOW(a_no_overflow, push, cnt_q < (QW+1)'(QDEPTH), "queue push while full")
	`RBF_ASSERT_NOW(a_no_underflow, pop, cnt_q != '0, "queue pop while empty")
	`RBF_ASSERT_NEXT(a_count_step, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "count slip")
endmodule
`default_nettype wire

// ===== hdl/rbf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rbf_back
	import rbf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] gamma,
	input  wire logic        q_valid,
	input  wire dist_t       q_data,
	output logic             pop,
	output logic             result_valid,
	input  wire logic        result_ready,
	output result_t          result
);
	back_state_t st_q, st_d;
	logic [DIST_W-1:0] dist_q;
	logic              last_q;
	logic [36:0]       plo_q, phi_q;
	logic [X_W-1:0]    x_q;
	logic [XQ_W-1:0]   xq_q;
	logic              zero_q;
	logic [ACC_W-1:0]  acc_q;
	logic [9:0]        bits_q;
	logic [3:0]        k_q;
	logic              rv_q;
	result_t           res_q;
	logic              load;
	logic [X_W-1:0]    xr;
	logic [23:0]       r30;
	logic [47:0]       r2;
	logic [60:0]       prod;
	logic [60:0]       prod_r;
	logic [ACC_W-1:0]  kv_w;

	assign xr     = x_q + X_W'(16'h8000);
	assign r30    = {xq_q[9:0], 14'd0};
	assign r2     = r30 * r30;
	assign prod   = 61'(acc_q) * 61'(exp_const(k_q));
	assign prod_r = prod + 61'(30'h2000_0000);
	assign kv_w   = (acc_q + ACC_W'(16'h4000)) >> 15;

	always_comb begin
		st_d = st_q;
		pop  = 1'b0;
		load = 1'b0;
		case (st_q)
			B_IDLE: begin
				if (q_valid) begin
					pop  = 1'b1;
					st_d = B_MUL_LO;
				end
			end
			B_MUL_LO: st_d = B_MUL_HI;
			B_MUL_HI: st_d = B_SUM;
			B_SUM:    st_d = B_ROUND;
			B_ROUND:  st_d = B_POLY;
			B_POLY:   st_d = B_EXP;
			B_EXP: begin
				if (k_q == 4'(TBL_N-1)) begin
					st_d = B_OUT;
				end
			end
			B_OUT: begin
				if (!rv_q || result_ready) begin
					load = 1'b1;
					st_d = B_IDLE;
				end
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			rv_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (load) begin
				rv_q <= 1'b1;
			end else if (result_ready) begin
				rv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				dist_q <= q_data.distance;
				last_q <= q_data.last;
			end
			B_MUL_LO: plo_q <= 37'(dist_q[20:0] * gamma);
			B_MUL_HI: phi_q <= 37'(dist_q[41:21] * gamma);
			B_SUM:    x_q   <= {phi_q, 21'd0} + X_W'(plo_q);
			B_ROUND: begin
				xq_q   <= xr[36:16];
				zero_q <= (x_q > (X_W'(1) << 36)) || xr[36];
			end
			B_POLY: begin
				acc_q  <= ACC_W'(31'h4000_0000 - 31'(r30) + 31'(r2[47:31]));
				bits_q <= xq_q[19:10];
				k_q    <= '0;
			end
			B_EXP: begin
				if (bits_q[0]) begin
					acc_q <= prod_r[60:30];
				end
				bits_q <= bits_q >> 1;
				k_q    <= k_q + 4'd1;
			end
			default: ;
		endcase
		if (load) begin
			res_q.kernel_value <= zero_q ? 16'd0 : kv_w[15:0];
			res_q.last         <= last_q;
		end
	end

	assign result_valid = rv_q;
	assign result       = res_q;
endmodule
`default_nettype wire

// ===== hdl/rbf_kernel_stream.sv =====
// Gaussian RBF kernel, K = exp(-gamma*||s-r||^2), Q1.15 out (0..32768, within 1 LSB).
// Words of kind 0 load the reference vector in order, wrapping after FEATURES words;
// words of kind 1 are sample features, and every FEATURES-th one yields a result,
// with last set on the sample that ends a run of sample_count. The front end takes
// one word per clock while the result queue has room: it reads the reference RAM,
// squares the difference and accumulates, two stages deep. Each finished distance
// waits in a QDEPTH-entry queue for the back end, a sequencer that takes one result
// at a time through the pop, 2 partial products for gamma, their sum, rounding, a
// polynomial step, 10 table steps and the load into the output register, holding
// the load while the previous result is still waiting to be taken.
// So with FEATURES >= 17 the input runs at one word per cycle while results are taken;
// smaller vectors, the default of 16 included, are paced by the back end once the
// queue has filled. Registers: 0 gamma (Q0.16),
// 1 sample_count; write them only while the block is idle. Reference entries not yet
// loaded read as garbage.
`timescale 1ns / 1ps
`default_nettype none
module rbf_kernel_stream
	import rbf_pkg::*;
#(
	parameter int FEATURES = 16,
	parameter int QDEPTH   = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire item_t       item,
	output logic             result_valid,
	input  wire logic        result_ready,
	output result_t          result,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	localparam int QW = $clog2(QDEPTH);

	logic [15:0]  gamma_q;
	logic [15:0]  count_q;
	logic         push, pop, q_valid;
	dist_t        push_data, q_data;
	logic [QW:0]  q_count;

	// register writes always complete; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_RST;
			count_q <= SAMPLE_COUNT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GAMMA:        gamma_q <= cfg_data;
				REG_SAMPLE_COUNT: count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rbf_front #(.FEATURES(FEATURES), .QDEPTH(QDEPTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.sample_count(count_q),
		.q_count     (q_count),
		.push        (push),
		.push_data   (push_data)
	);

	rbf_queue #(.QDEPTH(QDEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_count  (q_count)
	);

	rbf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.gamma       (gamma_q),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.pop         (pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);
endmodule
`default_nettype wire

// ===== test/tb_rbf_kernel_stream.sv =====
`timescale 1ns / 1ps
module tb_rbf_kernel_stream;
	import rbf_pkg::*;

	localparam int NFEAT = 16;

	// exp(-2^(k-6)) in Q0.30, one per bit of the rounded exponent from 2^-6 up
	localparam longint unsigned EXP_STEP [10] = '{
		64'd1057095000, 64'd1040706261, 64'd1008687096, 64'd947573834,
		64'd836230973, 64'd651257337, 64'd395007542, 64'd145315154,
		64'd19666268, 64'd360200
	};

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	item_t       item;
	logic        result_valid;
	logic        result_ready;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [15:0] cfg_data;

	rbf_kernel_stream u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// predictor state: shadow registers and the datapath's running sums
	logic [15:0]        gamma_q;
	logic [15:0]        run_len;
	logic signed [15:0] ref_vec [NFEAT];
	int                 ref_pos;
	int                 feat_pos;
	logic [41:0]        dist_acc;
	int unsigned        run_done;

	result_t     kernel_queue [$];
	int          mismatches;
	int          words_sent;
	int          kernels_seen;
	int          zero_kernels;
	int          unity_kernels;
	int          last_flags;
	bit          tx_steady;
	bit          rx_steady;
	int          rx_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Q.32 exponent (at most 16.0) to exp(-x) in Q1.15
	function automatic longint unsigned exp_q15(input longint unsigned x32);
		longint unsigned xq;
		longint unsigned r30;
		longint unsigned acc;
		xq = (x32 + 64'h8000) >> 16;
		if (xq >= (64'd1 << 20))
			return 0;
		r30 = (xq & 64'h3ff) << 14;
		acc = (64'd1 << 30) - r30 + ((r30 * r30) >> 31);
		for (int k = 0; k < 10; k++)
			if ((xq >> (k + 10)) & 64'd1)
				acc = (acc * EXP_STEP[k] + (64'd1 << 29)) >> 30;
		return (acc + 64'h4000) >> 15;
	endfunction

	task automatic kernel_predict(input item_t w);
		int              d;
		longint unsigned x32;
		result_t         r;
		if (w.kind == KIND_REF) begin
			ref_vec[ref_pos] = w.feature;
			ref_pos = (ref_pos + 1) % NFEAT;
			return;
		end
		d = int'(w.feature) - int'(ref_vec[feat_pos]);
		dist_acc = dist_acc + 42'(longint'(d) * longint'(d));
		feat_pos++;
		if (feat_pos < NFEAT)
			return;
		x32 = 64'(dist_acc) * 64'(gamma_q);
		r.kernel_value = (x32 > (64'd16 << 32)) ? 16'd0 : 16'(exp_q15(x32));
		r.last = (run_done + 1 >= 32'(run_len));
		run_done = r.last ? 0 : run_done + 1;
		feat_pos = 0;
		dist_acc = '0;
		kernel_queue.push_back(r);
	endtask

	// mostly back to back, sometimes a short gap, rarely a long gap
	function automatic int pick_gap(input bit steady);
		int p;
		if (steady)
			return 0;
		p = $urandom_range(99);
		if (p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(3, 1);
		return $urandom_range(30, 5);
	endfunction

	// offer one word after a random gap; valid stays up into the next call when gap is 0
	task automatic send_word(input logic kind, input logic [15:0] feature);
		int gap;
		gap = pick_gap(tx_steady);
		if (gap > 0) begin
			@(negedge clk) item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item.kind <= kind;
		item.feature <= feature;
		do @(posedge clk); while (!item_ready);
		kernel_predict('{kind: kind, feature: feature});
		words_sent++;
	endtask

	task automatic tx_idle();
		@(negedge clk) item_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		tx_idle();
		while (kernel_queue.size() != 0)
			@(posedge clk);
		// margin for the back end's sequence and the front pipe
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_GAMMA)
			gamma_q = data;
		else if (idx == REG_SAMPLE_COUNT)
			run_len = data;
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// a sample close to the stored reference, spread set by a random scale
	task automatic send_sample(input int scale);
		logic signed [15:0] delta;
		for (int i = 0; i < NFEAT; i++) begin
			delta = 16'($signed($urandom_range((1 << scale), 0)) - (1 << (scale - 1)));
			send_word(KIND_SAMPLE, 16'(ref_vec[feat_pos] + delta));
		end
	endtask

	task automatic load_reference();
		for (int i = 0; i < NFEAT; i++)
			send_word(KIND_REF, 16'($urandom));
	endtask

	// receiver: random stalls, a steady mode, and a counted hold-off on request
	initial begin : rx_drive
		int stall;
		stall = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				result_ready <= 1'b0;
				rx_hold--;
			end else if (rx_steady) begin
				result_ready <= 1'b1;
			end else if (stall > 0) begin
				result_ready <= 1'b0;
				stall--;
			end else begin
				result_ready <= 1'b1;
				if ($urandom_range(3) == 0)
					stall = pick_gap(1'b0);
			end
		end
	end

	// every accepted result against the oldest outstanding kernel
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (kernel_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kernel %0d last %0b",
						result.kernel_value, result.last);
			end else begin
				want = kernel_queue.pop_front();
				kernels_seen++;
				if (want.kernel_value == 0)
					zero_kernels++;
				if (want.kernel_value == 16'd32768)
					unity_kernels++;
				if (want.last)
					last_flags++;
				if (result.kernel_value !== want.kernel_value || result.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: kernel %0d/%0d last %0b/%0b (exp/got)",
							kernels_seen, want.kernel_value, result.kernel_value,
							want.last, result.last);
				end
			end
		end
	end

	// extremes: identical vectors, widest distance, every sign bit
	task automatic test_directed();
		write_reg(REG_GAMMA, 16'd3277);
		write_reg(REG_SAMPLE_COUNT, 16'd2);
		for (int i = 0; i < NFEAT; i++)
			send_word(KIND_REF, (i % 2) ? 16'h8000 : 16'h7fff);
		for (int i = 0; i < NFEAT; i++)
			send_word(KIND_SAMPLE, 16'(ref_vec[i]));
		for (int i = 0; i < NFEAT; i++)
			send_word(KIND_SAMPLE, (i % 2) ? 16'h7fff : 16'h8000);
		wait_drained();
	endtask

	// register extremes; single reference words interleave with samples
	task automatic test_settings();
		logic [15:0] gammas [4];
		logic [15:0] counts [4];
		gammas = '{16'd1, 16'd65535, 16'd3277, 16'($urandom_range(65535, 1))};
		counts = '{16'd1, 16'd65535, 16'd3, 16'($urandom_range(7, 2))};
		for (int s = 0; s < 4; s++) begin
			write_reg(REG_GAMMA, gammas[s]);
			write_reg(REG_SAMPLE_COUNT, counts[s]);
			for (int n = 0; n < 4; n++) begin
				send_sample($urandom_range(gammas[s] > 1000 ? 8 : 15, 1));
				if (n == 1)
					send_word(KIND_REF, 16'($urandom));
			end
			wait_drained();
		end
	endtask

	// bulk random: mostly near-reference samples, some noise and reloads
	task automatic test_random();
		write_reg(REG_GAMMA, 16'd200);
		write_reg(REG_SAMPLE_COUNT, 16'd5);
		repeat (30) begin
			case ($urandom_range(9))
				0: load_reference();
				1: for (int i = 0; i < NFEAT; i++)
					send_word(KIND_SAMPLE, 16'($urandom));
				2: send_word(KIND_REF, 16'($urandom));
				default: send_sample($urandom_range(12, 1));
			endcase
		end
		wait_drained();
	endtask

	// receiver holds off while the sender keeps offering, so the queue fills; then both sides run steady
	task automatic test_backpressure();
		tx_steady = 1'b1;
		rx_hold = 300;
		repeat (8) send_sample($urandom_range(10, 2));
		tx_steady = 1'b0;
		wait_drained();
		rx_steady = 1'b1;
		tx_steady = 1'b1;
		repeat (4) send_sample(6);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		wait_drained();
	endtask

	initial begin
		rx_hold = 0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		mismatches = 0;
		words_sent = 0;
		kernels_seen = 0;
		zero_kernels = 0;
		unity_kernels = 0;
		last_flags = 0;
		gamma_q = GAMMA_RST;
		run_len = SAMPLE_COUNT_RST;
		ref_pos = 0;
		feat_pos = 0;
		dist_acc = '0;
		run_done = 0;
		foreach (ref_vec[i])
			ref_vec[i] = '0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		test_directed();
		test_settings();
		test_random();
		test_backpressure();

		$display("%0d words in, %0d kernels checked (%0d zero, %0d unity, %0d run ends)",
			words_sent, kernels_seen, zero_kernels, unity_kernels, last_flags);
		$display("gamma and sample_count swept over their extremes, with stalls both sides");
		if (mismatches == 0 && kernel_queue.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, kernel_queue.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", kernel_queue.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
